// ===== src/two_stacks_shared_memory_macros.svh =====
// Assertion macros for the two-stack block checker.
// Used by the checker file only; needs clk and rst in the including scope.
`ifndef TWO_STACKS_SHARED_MEMORY_MACROS_SVH
`define TWO_STACKS_SHARED_MEMORY_MACROS_SVH

// Same-cycle implication, disabled during reset
`define TSS_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("two-stack checker: same-cycle property failed");

// Next-cycle implication, disabled during reset
`define TSS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("two-stack checker: next-cycle property failed");

`endif

// ===== src/tss_pkg.sv =====
// Shared types and constants for the two-stack block.
// No dependencies; imported by every module of the block except tss_ram.
package tss_pkg;

  localparam int MAX_ENTRIES = 1024;
  localparam int ADDR_W      = $clog2(MAX_ENTRIES);
  localparam int CNT_W       = 11;
  localparam int DATA_W      = 32;
  localparam logic [CNT_W-1:0] CAP_RESET = CNT_W'(1024);
  localparam logic [CNT_W-1:0] CAP_MAX   = CNT_W'(MAX_ENTRIES);

  typedef enum logic [1:0] {
    REQ_PUSH_ONE = 2'd0,
    REQ_PUSH_TWO = 2'd1,
    REQ_POP_ONE  = 2'd2,
    REQ_POP_TWO  = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    CS_IDLE,
    CS_EXEC,
    CS_RD_ONE,
    CS_RD_TWO,
    CS_CAP_TWO,
    CS_OUT
  } ctrl_state_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic load;     // latch the accepted item
    logic exec;     // update counts, write on push
    logic rd_one;   // address stack one top
    logic rd_two;   // address stack two top
    logic cap_one;  // capture stack one top
    logic cap_two;  // capture stack two top
  } dp_cmd_t;

endpackage

// ===== src/tss_ram.sv =====
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module tss_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== src/tss_ctrl.sv =====
// Controller state machine for the two-stack block.
// Depends on tss_pkg; drives datapath commands, busy and done.
module tss_ctrl
  import tss_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    start,
  output logic    busy,
  output logic    done,
  output dp_cmd_t cmd
);

  ctrl_state_t state, state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= CS_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    busy       = 1'b0;
    done       = 1'b0;
    case (state)
      CS_IDLE, CS_OUT: begin
        done = (state == CS_OUT);
        if (start) begin
          cmd.load   = 1'b1;
          state_next = CS_EXEC;
        end else begin
          state_next = CS_IDLE;
        end
      end
      CS_EXEC: begin
        busy       = 1'b1;
        cmd.exec   = 1'b1;
        state_next = CS_RD_ONE;
      end
      CS_RD_ONE: begin
        busy       = 1'b1;
        cmd.rd_one = 1'b1;
        state_next = CS_RD_TWO;
      end
      CS_RD_TWO: begin
        busy        = 1'b1;
        cmd.rd_two  = 1'b1;
        cmd.cap_one = 1'b1;
        state_next  = CS_CAP_TWO;
      end
      CS_CAP_TWO: begin
        busy        = 1'b1;
        cmd.cap_two = 1'b1;
        state_next  = CS_OUT;
      end
      default: begin
        state_next = CS_IDLE;
      end
    endcase
  end

endmodule

// ===== src/tss_datapath.sv =====
// Datapath for the two-stack block: counts, capacity, shared RAM, result registers.
// Depends on tss_pkg and tss_ram.
module tss_datapath
  import tss_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  dp_cmd_t                  cmd,
  input  logic [1:0]               req_type,
  input  logic signed [DATA_W-1:0] push_value,
  input  logic                     cfg_write,
  input  logic [CNT_W-1:0]         cfg_data,
  output logic [1:0]               status,
  output logic [CNT_W-1:0]         depth_one,
  output logic [CNT_W-1:0]         depth_two,
  output logic signed [DATA_W-1:0] top_one,
  output logic                     top_one_valid,
  output logic signed [DATA_W-1:0] top_two,
  output logic                     top_two_valid
);

  logic [1:0]               req_q;
  logic signed [DATA_W-1:0] val_q;
  logic [CNT_W-1:0]         capacity;
  logic [CNT_W-1:0]         count_one;
  logic [CNT_W-1:0]         count_two;
  status_t                  status_q;
  status_t                  status_next;
  logic signed [DATA_W-1:0] top_one_q;
  logic signed [DATA_W-1:0] top_two_q;

  logic [CNT_W-1:0]  cap_eff;
  logic [CNT_W:0]    fill;
  logic              full;
  logic [CNT_W-1:0]  addr_push_two;
  logic [CNT_W-1:0]  addr_top_one;
  logic [CNT_W-1:0]  addr_top_two;
  logic              we;
  logic [ADDR_W-1:0] waddr;
  logic [ADDR_W-1:0] raddr;
  logic [DATA_W-1:0] rdata;

  // Capacity in effect and fill test
  assign cap_eff = (capacity > CAP_MAX) ? CAP_MAX : capacity;
  assign fill    = {1'b0, count_one} + {1'b0, count_two};
  assign full    = fill >= {1'b0, cap_eff};

  // Entry addresses
  assign addr_push_two = cap_eff - CNT_W'(1) - count_two;
  assign addr_top_one  = count_one - CNT_W'(1);
  assign addr_top_two  = cap_eff - count_two;

  assign we    = cmd.exec && !full &&
                 (req_q == REQ_PUSH_ONE || req_q == REQ_PUSH_TWO);
  assign waddr = (req_q == REQ_PUSH_ONE) ? count_one[ADDR_W-1:0]
                                         : addr_push_two[ADDR_W-1:0];
  assign raddr = cmd.rd_two ? addr_top_two[ADDR_W-1:0] : addr_top_one[ADDR_W-1:0];

  tss_ram #(
    .WIDTH (DATA_W),
    .DEPTH (MAX_ENTRIES)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (val_q),
    .raddr (raddr),
    .rdata (rdata)
  );

  // Capacity register
  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAP_RESET;
    end else if (cfg_write) begin
      capacity <= cfg_data;
    end
  end

  // Latch the accepted item
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_q <= req_type;
      val_q <= push_value;
    end
  end

  // Status of the held request
  always_comb begin
    case (req_t'(req_q))
      REQ_PUSH_ONE, REQ_PUSH_TWO: status_next = full ? ST_FULL : ST_DONE;
      REQ_POP_ONE:                status_next = (count_one == '0) ? ST_EMPTY : ST_DONE;
      default:                    status_next = (count_two == '0) ? ST_EMPTY : ST_DONE;
    endcase
  end

  // Apply the request to the counts
  always_ff @(posedge clk) begin
    if (rst) begin
      count_one <= '0;
      count_two <= '0;
      status_q  <= ST_DONE;
    end else if (cmd.exec) begin
      status_q <= status_next;
      case (req_t'(req_q))
        REQ_PUSH_ONE: begin
          if (!full) count_one <= count_one + CNT_W'(1);
        end
        REQ_PUSH_TWO: begin
          if (!full) count_two <= count_two + CNT_W'(1);
        end
        REQ_POP_ONE: begin
          if (count_one != '0) count_one <= count_one - CNT_W'(1);
        end
        default: begin
          if (count_two != '0) count_two <= count_two - CNT_W'(1);
        end
      endcase
    end
  end

  // Capture top values, zero when empty or out of range
  always_ff @(posedge clk) begin
    if (cmd.cap_one) begin
      top_one_q <= (count_one != '0) ? $signed(rdata) : '0;
    end
    if (cmd.cap_two) begin
      top_two_q <= (count_two != '0 && count_two <= cap_eff) ? $signed(rdata) : '0;
    end
  end

  assign status        = status_q;
  assign depth_one     = count_one;
  assign depth_two     = count_two;
  assign top_one       = top_one_q;
  assign top_one_valid = (count_one != '0);
  assign top_two       = top_two_q;
  assign top_two_valid = (count_two != '0);

endmodule

// ===== src/two_stacks_shared_memory.sv =====
// Two LIFO stacks in one shared 1024 x 32 memory. Start is taken at a clock edge
// where busy is low; the result follows on done for a single cycle, after states
// EXEC, RD_ONE, RD_TWO and CAP_TWO, and the receiver cannot stall it. A new item
// can be taken in the same cycle that done is high, but none while busy. The pace
// is set by the single read port of the shared RAM, whose registered read must
// fetch the two top values one after the other following the count update and
// any push write. The capacity register is written through cfg_valid/cfg_ready
// (always ready); values above 1024 act as 1024. The user must write it only
// while the block is idle; the block itself does not enforce this. Memory contents
// are not cleared at reset. Depends on tss_pkg, tss_ctrl, tss_datapath and tss_ram.
module two_stacks_shared_memory
  import tss_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  output logic                     busy,
  input  logic [1:0]               req_type,
  input  logic signed [DATA_W-1:0] push_value,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [CNT_W-1:0]         cfg_data,
  output logic                     done,
  output logic [1:0]               status,
  output logic [CNT_W-1:0]         depth_one,
  output logic [CNT_W-1:0]         depth_two,
  output logic signed [DATA_W-1:0] top_one,
  output logic                     top_one_valid,
  output logic signed [DATA_W-1:0] top_two,
  output logic                     top_two_valid
);

  dp_cmd_t cmd;

  assign cfg_ready = 1'b1;

  tss_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .done  (done),
    .cmd   (cmd)
  );

  tss_datapath u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .req_type      (req_type),
    .push_value    (push_value),
    .cfg_write     (cfg_valid && cfg_ready),
    .cfg_data      (cfg_data),
    .status        (status),
    .depth_one     (depth_one),
    .depth_two     (depth_two),
    .top_one       (top_one),
    .top_one_valid (top_one_valid),
    .top_two       (top_two),
    .top_two_valid (top_two_valid)
  );

endmodule

// ===== src/tss_checker.sv =====
// Port-level checker for the two-stack block, bound to the top level.
// Depends on tss_pkg and two_stacks_shared_memory_macros.svh.
`include "two_stacks_shared_memory_macros.svh"

module tss_checker
  import tss_pkg::*;
(
  input logic                     clk,
  input logic                     rst,
  input logic                     start,
  input logic                     busy,
  input logic                     done,
  input logic [CNT_W-1:0]         depth_one,
  input logic [CNT_W-1:0]         depth_two,
  input logic signed [DATA_W-1:0] top_one,
  input logic                     top_one_valid,
  input logic                     top_two_valid
);

  // A taken item keeps the block busy next cycle
  `TSS_ASSERT_NEXT(a_take_busy, start && !busy, busy)
  // A result strobe lasts one cycle
  `TSS_ASSERT_NEXT(a_done_single, done, !done)
  // Valid flags follow the depths
  `TSS_ASSERT_NOW(a_valid_one, done, top_one_valid == (depth_one != '0))
  `TSS_ASSERT_NOW(a_valid_two, done, top_two_valid == (depth_two != '0))
  // An empty stack one reports a zero top
  `TSS_ASSERT_NOW(a_empty_zero, done && !top_one_valid, top_one == '0)

endmodule

bind two_stacks_shared_memory tss_checker u_tss_checker (.*);

// ===== sim/two_stacks_shared_memory_test.sv =====
// Self-checking testbench for the two-stack shared memory block.
// Drives push/pop items and capacity writes, predicts every result in-line.
// Depends on tss_pkg and two_stacks_shared_memory.
`timescale 1ns / 1ps

module two_stacks_shared_memory_test;
  import tss_pkg::*;

  localparam int STALL_LIMIT = 1000;

  typedef struct packed {
    req_t                     kind;
    logic signed [DATA_W-1:0] value;
  } stack_req_t;

  typedef struct {
    status_t                  status;
    logic [CNT_W-1:0]         depth_one;
    logic [CNT_W-1:0]         depth_two;
    logic signed [DATA_W-1:0] top_one;
    logic                     top_one_valid;
    logic signed [DATA_W-1:0] top_two;
    logic                     top_two_valid;
  } stack_result_t;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     start = 1'b0;
  logic                     busy;
  logic [1:0]               req_type = '0;
  logic signed [DATA_W-1:0] push_value = '0;
  logic                     cfg_valid = 1'b0;
  logic                     cfg_ready;
  logic [CNT_W-1:0]         cfg_data = '0;
  logic                     done;
  logic [1:0]               status;
  logic [CNT_W-1:0]         depth_one;
  logic [CNT_W-1:0]         depth_two;
  logic signed [DATA_W-1:0] top_one;
  logic                     top_one_valid;
  logic signed [DATA_W-1:0] top_two;
  logic                     top_two_valid;

  two_stacks_shared_memory dut (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .req_type      (req_type),
    .push_value    (push_value),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data),
    .done          (done),
    .status        (status),
    .depth_one     (depth_one),
    .depth_two     (depth_two),
    .top_one       (top_one),
    .top_one_valid (top_one_valid),
    .top_two       (top_two),
    .top_two_valid (top_two_valid)
  );

  always #5 clk = ~clk;

  // Items waiting to be sent, and results waiting to arrive
  stack_req_t    pending_reqs[$];
  stack_result_t awaited_results[$];
  int            errors = 0;
  int            cfg_writes = 0;
  bit            took_item = 1'b0;
  int            stall_cycles = 0;

  // Shadow of the block: shared store, both depths, capacity
  logic [DATA_W-1:0] store_model [MAX_ENTRIES];
  int unsigned       fill_one = 0;
  int unsigned       fill_two = 0;
  logic [CNT_W-1:0]  cap_model = CAP_RESET;

  // Stimulus planning view: depths and which entries have been written
  int unsigned plan_one = 0;
  int unsigned plan_two = 0;
  int unsigned plan_cap = 1024;
  bit          written_entries [MAX_ENTRIES];

  task automatic flag_error(input string msg);
    $display("ERROR at %0t: %s", $time, msg);
    errors++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want)
      flag_error($sformatf("%s got %h want %h", name, got, want));
  endtask

  // Apply one push or pop to the shadow and return the result it yields
  function automatic stack_result_t stack_engine_step(req_t kind, logic [DATA_W-1:0] value);
    int unsigned   cap_eff = (cap_model > CAP_MAX) ? MAX_ENTRIES : int'(cap_model);
    bit            is_full = (fill_one + fill_two) >= cap_eff;
    int unsigned   slot;
    stack_result_t r;
    r.status = ST_DONE;
    case (kind)
      REQ_PUSH_ONE: begin
        if (is_full) begin
          r.status = ST_FULL;
        end else begin
          if (fill_one < MAX_ENTRIES) store_model[fill_one] = value;
          fill_one++;
        end
      end
      REQ_PUSH_TWO: begin
        if (is_full) begin
          r.status = ST_FULL;
        end else begin
          slot = cap_eff - 1 - fill_two;
          if (slot < MAX_ENTRIES) store_model[slot] = value;
          fill_two++;
        end
      end
      REQ_POP_ONE: begin
        if (fill_one == 0) r.status = ST_EMPTY;
        else fill_one--;
      end
      default: begin
        if (fill_two == 0) r.status = ST_EMPTY;
        else fill_two--;
      end
    endcase
    r.depth_one = CNT_W'(fill_one);
    r.depth_two = CNT_W'(fill_two);
    r.top_one = '0;
    r.top_one_valid = 1'b0;
    r.top_two = '0;
    r.top_two_valid = 1'b0;
    if (fill_one != 0) begin
      r.top_one_valid = 1'b1;
      r.top_one = store_model[fill_one - 1];
    end
    // stack two top reads as zero once it sits below entry 0
    if (fill_two != 0) begin
      r.top_two_valid = 1'b1;
      if (fill_two <= cap_eff) r.top_two = store_model[cap_eff - fill_two];
    end
    return r;
  endfunction

  // Monitor: take capacity writes and items, check every result
  always @(posedge clk) begin : watch_ports
    stack_result_t want;
    if (!rst) begin
      if (cfg_valid && cfg_ready) begin
        cap_model = cfg_data;
        cfg_writes++;
      end
      if (done) begin
        if (awaited_results.size() == 0) begin
          flag_error("result arrived with nothing awaited");
        end else begin
          want = awaited_results.pop_front();
          check_field("status", 32'(status), 32'(want.status));
          check_field("depth_one", 32'(depth_one), 32'(want.depth_one));
          check_field("depth_two", 32'(depth_two), 32'(want.depth_two));
          check_field("top_one", top_one, want.top_one);
          check_field("top_one_valid", 32'(top_one_valid), 32'(want.top_one_valid));
          check_field("top_two", top_two, want.top_two);
          check_field("top_two_valid", 32'(top_two_valid), 32'(want.top_two_valid));
        end
      end
      if (start && !busy) begin
        awaited_results.push_back(stack_engine_step(req_t'(req_type), push_value));
        took_item = 1'b1;
      end
    end
  end

  // Driver: send pending items in bursts with random gaps between them
  int unsigned burst_left = 8;
  int unsigned gap_left = 0;

  always @(negedge clk) begin : drive_reqs
    bit was_taken;
    if (!rst) begin
      was_taken = took_item;
      if (was_taken) begin
        took_item = 1'b0;
        void'(pending_reqs.pop_front());
      end
      // hold an item that has not been taken yet
      if (!start || was_taken) begin
        if (gap_left > 0) begin
          gap_left--;
          start <= 1'b0;
        end else if (pending_reqs.size() > 0) begin
          start <= 1'b1;
          req_type <= pending_reqs[0].kind;
          push_value <= pending_reqs[0].value;
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 24);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
          end
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Watchdog: end the run when nothing moves for too long
  always @(posedge clk) begin
    if (!rst) begin
      if ((start && !busy) || done || (cfg_valid && cfg_ready)) stall_cycles = 0;
      else stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("watchdog: no progress for %0d cycles", STALL_LIMIT);
        $display("two_stacks_shared_memory_test NOT OK");
        $finish;
      end
    end
  end

  function automatic logic [DATA_W-1:0] pick_value();
    case ($urandom_range(0, 7))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'h0000_0000;
      3: return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  // Queue one item and advance the planning view
  task automatic queue_req(input req_t kind, input logic [DATA_W-1:0] value);
    stack_req_t item;
    bit is_full;
    item.kind = kind;
    item.value = value;
    pending_reqs.push_back(item);
    is_full = (plan_one + plan_two) >= plan_cap;
    case (kind)
      REQ_PUSH_ONE: if (!is_full) begin
        written_entries[plan_one] = 1'b1;
        plan_one++;
      end
      REQ_PUSH_TWO: if (!is_full) begin
        written_entries[plan_cap - 1 - plan_two] = 1'b1;
        plan_two++;
      end
      REQ_POP_ONE: if (plan_one != 0) plan_one--;
      default: if (plan_two != 0) plan_two--;
    endcase
  endtask

  // Stack two may stay put only if its whole region under the new capacity is written
  function automatic bit stack_two_fits(int unsigned cap);
    if (plan_two > cap) return 1'b0;
    for (int unsigned i = cap - plan_two; i < cap; i++)
      if (!written_entries[i]) return 1'b0;
    return 1'b1;
  endfunction

  // Wait until every item has gone in and every result has come out
  task automatic wait_idle();
    do @(negedge clk);
    while (pending_reqs.size() != 0 || start || awaited_results.size() != 0 || busy);
  endtask

  task automatic set_capacity(input int unsigned cap, input bit keep_data);
    int unsigned n;
    // empty stack two first where its entries would land on unwritten memory
    if (!keep_data && plan_two > 0 && !stack_two_fits(cap)) begin
      n = plan_two;
      repeat (n) queue_req(REQ_POP_TWO, $urandom);
    end
    wait_idle();
    n = cfg_writes;
    cfg_valid <= 1'b1;
    cfg_data <= CNT_W'(cap);
    do @(negedge clk);
    while (cfg_writes == n);
    cfg_valid <= 1'b0;
    plan_cap = cap;
  endtask

  // Random items in segments that fill, drain, mix, or work one stack
  task automatic random_phase(input int n);
    int unsigned mode;
    int unsigned seg_left;
    bit          seg_stack;
    bit          is_push;
    bit          which;
    int unsigned r;
    seg_left = 0;
    mode = 0;
    seg_stack = 1'b0;
    for (int i = 0; i < n; i++) begin
      if (i == n / 2) wait_idle();
      if (seg_left == 0) begin
        mode = $urandom_range(0, 3);
        seg_left = $urandom_range(4, 30);
        seg_stack = 1'($urandom_range(0, 1));
      end
      seg_left--;
      r = $urandom_range(0, 99);
      which = 1'($urandom_range(0, 1));
      case (mode)
        0: is_push = r < 80;
        1: is_push = r < 20;
        2: is_push = r < 50;
        default: begin
          is_push = r < 60;
          which = seg_stack;
        end
      endcase
      // a little noise on top of the segment shape
      if ($urandom_range(0, 19) == 0) begin
        is_push = 1'($urandom_range(0, 1));
        which = 1'($urandom_range(0, 1));
      end
      if (is_push)
        queue_req(which ? REQ_PUSH_TWO : REQ_PUSH_ONE, pick_value());
      else
        queue_req(which ? REQ_POP_TWO : REQ_POP_ONE, $urandom);
    end
  endtask

  initial begin : run_test
    int unsigned caps [10];
    int unsigned cap;
    caps = '{5, 2, 16, 1024, 3, 37, 0, 1023, 8, 2};
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Empty pops, extreme values on both stacks, drain to empty
    set_capacity(1024, 1'b0);
    queue_req(REQ_POP_ONE, 32'h0);
    queue_req(REQ_POP_TWO, 32'hFFFF_FFFF);
    queue_req(REQ_PUSH_ONE, 32'h7FFF_FFFF);
    queue_req(REQ_PUSH_ONE, 32'h8000_0000);
    queue_req(REQ_PUSH_TWO, 32'h0000_0000);
    queue_req(REQ_PUSH_TWO, 32'hFFFF_FFFF);
    queue_req(REQ_POP_ONE, 32'h5555_5555);
    queue_req(REQ_POP_ONE, 32'hAAAA_AAAA);
    queue_req(REQ_POP_ONE, 32'h0);
    queue_req(REQ_POP_TWO, 32'h0);
    queue_req(REQ_POP_TWO, 32'h0);
    queue_req(REQ_POP_TWO, 32'h0);

    // Fill a small memory from both ends, then push into the full memory
    set_capacity(8, 1'b0);
    queue_req(REQ_PUSH_ONE, 32'hA5A5_A5A5);
    queue_req(REQ_PUSH_ONE, 32'h5A5A_5A5A);
    for (int i = 1; i <= 6; i++) queue_req(REQ_PUSH_TWO, 32'h1111_1111 * i);
    queue_req(REQ_PUSH_ONE, 32'hDEAD_BEEF);

    // Shrink under held data: stack two top drops below entry 0, then drain
    set_capacity(4, 1'b1);
    repeat (6) queue_req(REQ_POP_TWO, $urandom);

    foreach (caps[k]) begin
      cap = (caps[k] == 0) ? $urandom_range(2, 64) : caps[k];
      set_capacity(cap, 1'b0);
      random_phase((cap >= 1000) ? 100 : 130);
    end

    wait_idle();
    repeat (10) @(posedge clk);
    if (awaited_results.size() != 0)
      flag_error($sformatf("%0d results never arrived", awaited_results.size()));
    if (errors == 0) begin
      $display("two_stacks_shared_memory_test OK");
    end else begin
      $display("two_stacks_shared_memory_test NOT OK");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+src
src/tss_pkg.sv
src/tss_ram.sv
src/tss_ctrl.sv
src/tss_datapath.sv
src/two_stacks_shared_memory.sv
src/tss_checker.sv
sim/two_stacks_shared_memory_test.sv
